// ===== hw/rtl/hbld_pkg.sv =====
// ---------------------------------------------------------------------------
// hbld_pkg
// Shared types and constants for the heartbeat loss detector: command codes,
// register map, beat payload structs and per-channel control.
// ---------------------------------------------------------------------------
package hbld_pkg;

    // Item kinds
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
    localparam logic [1:0] CMD_SCAN      = 2'd2;

    // Register map (index = byte address / 4)
    localparam int          PADDR_W        = 5;
    localparam int          REG_IDX_W      = 3;
    localparam logic [2:0]  REG_TIMEOUT_0  = 3'd0;
    localparam logic [2:0]  REG_TIMEOUT_1  = 3'd1;
    localparam logic [2:0]  REG_TIMEOUT_2  = 3'd2;
    localparam logic [2:0]  REG_TIMEOUT_3  = 3'd3;
    localparam logic [2:0]  REG_MISS_LIMIT = 3'd4;

    localparam int TIMEOUT_REGS = 4;
    localparam int TIMEOUT_W    = 16;
    localparam int MISS_W       = 10;
    localparam int FLAGS_W      = 4;

    // Reset values of the registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST_LOW  = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST_HIGH = 16'd1500;
    localparam logic [MISS_W-1:0]    MISS_LIMIT_RST   = 10'd500;
    localparam logic [MISS_W-1:0]    MISS_TOP         = 10'd1023;

    typedef logic [TIMEOUT_REGS-1:0][TIMEOUT_W-1:0] timeout_arr_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] channel;
    } in_beat_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] lost_flags;
        logic               selected_lost;
    } out_beat_t;

    typedef struct packed {
        logic heartbeat;
        logic scan;
    } chan_ctl_t;

endpackage

// ===== hw/rtl/hbld_cfg.sv =====
// ---------------------------------------------------------------------------
// hbld_cfg
// APB register file: four channel timeouts and the miss limit.
// ---------------------------------------------------------------------------
module hbld_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbld_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output hbld_pkg::timeout_arr_t        timeouts,
    output logic [hbld_pkg::MISS_W-1:0]   miss_limit
);

    hbld_pkg::timeout_arr_t              timeout_reg;
    logic [hbld_pkg::MISS_W-1:0]         miss_limit_reg;
    logic [hbld_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hbld_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg[0] <= hbld_pkg::TIMEOUT_RST_LOW;
            timeout_reg[1] <= hbld_pkg::TIMEOUT_RST_LOW;
            timeout_reg[2] <= hbld_pkg::TIMEOUT_RST_LOW;
            timeout_reg[3] <= hbld_pkg::TIMEOUT_RST_HIGH;
            miss_limit_reg <= hbld_pkg::MISS_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                hbld_pkg::REG_TIMEOUT_0:  timeout_reg[0] <= pwdata[hbld_pkg::TIMEOUT_W-1:0];
                hbld_pkg::REG_TIMEOUT_1:  timeout_reg[1] <= pwdata[hbld_pkg::TIMEOUT_W-1:0];
                hbld_pkg::REG_TIMEOUT_2:  timeout_reg[2] <= pwdata[hbld_pkg::TIMEOUT_W-1:0];
                hbld_pkg::REG_TIMEOUT_3:  timeout_reg[3] <= pwdata[hbld_pkg::TIMEOUT_W-1:0];
                hbld_pkg::REG_MISS_LIMIT: miss_limit_reg <= pwdata[hbld_pkg::MISS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            hbld_pkg::REG_TIMEOUT_0:  prdata = {16'd0, timeout_reg[0]};
            hbld_pkg::REG_TIMEOUT_1:  prdata = {16'd0, timeout_reg[1]};
            hbld_pkg::REG_TIMEOUT_2:  prdata = {16'd0, timeout_reg[2]};
            hbld_pkg::REG_TIMEOUT_3:  prdata = {16'd0, timeout_reg[3]};
            hbld_pkg::REG_MISS_LIMIT: prdata = {22'd0, miss_limit_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign timeouts   = timeout_reg;
    assign miss_limit = miss_limit_reg;

endmodule

// ===== hw/rtl/hbld_chan.sv =====
// ---------------------------------------------------------------------------
// hbld_chan
// One watchdog channel: heartbeat stamp, miss counter and lost flag, updated
// on a heartbeat or scan.
// ---------------------------------------------------------------------------
module hbld_chan
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  hbld_pkg::chan_ctl_t             ctl,
    input  logic [TIME_WIDTH-1:0]           now,
    input  logic [hbld_pkg::TIMEOUT_W-1:0]  timeout,
    input  logic [hbld_pkg::MISS_W-1:0]     miss_limit,
    output logic                            lost_next
);

    logic [TIME_WIDTH-1:0]        last_seen_reg;
    logic [TIME_WIDTH-1:0]        last_seen_next;
    logic [hbld_pkg::MISS_W-1:0]  miss_count_reg;
    logic [hbld_pkg::MISS_W-1:0]  miss_count_next;
    logic                         lost_reg;
    logic [TIME_WIDTH-1:0]        stamp;
    logic [TIME_WIDTH-1:0]        elapsed;
    logic [hbld_pkg::MISS_W-1:0]  miss_inc;
    logic                         expired;

    // Pull a stamp that lies ahead of now back to one tick before now
    assign stamp   = (now < last_seen_reg) ? (now - 1'b1) : last_seen_reg;
    assign elapsed = now - stamp;
    assign expired = elapsed > {{(TIME_WIDTH-hbld_pkg::TIMEOUT_W){1'b0}}, timeout};
    assign miss_inc = (miss_count_reg < hbld_pkg::MISS_TOP) ? (miss_count_reg + 1'b1)
                                                            : miss_count_reg;

    // Next channel state
    always_comb
    begin
        last_seen_next  = last_seen_reg;
        miss_count_next = miss_count_reg;
        lost_next       = lost_reg;
        if (ctl.heartbeat)
        begin
            last_seen_next = now;
        end
        else if (ctl.scan)
        begin
            last_seen_next = stamp;
            if (expired)
            begin
                if (miss_inc > miss_limit)
                begin
                    miss_count_next = '0;
                    lost_next       = 1'b1;
                end
                else
                begin
                    miss_count_next = miss_inc;
                end
            end
            else
            begin
                miss_count_next = '0;
                lost_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg  <= '0;
            miss_count_reg <= '0;
            lost_reg       <= 1'b0;
        end
        else
        begin
            last_seen_reg  <= last_seen_next;
            miss_count_reg <= miss_count_next;
            lost_reg       <= lost_next;
        end
    end

endmodule

// ===== hw/rtl/heartbeat_loss_detector_top.sv =====
// ---------------------------------------------------------------------------
// heartbeat_loss_detector_top
// Multi-channel heartbeat watchdog with an APB register file.
// ---------------------------------------------------------------------------
// Each input beat is a tick, a heartbeat for one channel, or a scan of all
// channels, and returns exactly one output beat with the lost flags of the
// first four channels and the flag of the named channel, as they stand after
// that item. An accepted beat lands in an input register; when it moves on,
// it updates the time counter and the channel units and is written to the
// output register at the same edge. Throughput is one item per cycle; the
// output register keeps taking items as long as the sink does not stall.
// Timeouts and the miss limit must be written over APB at byte addresses 0x0
// to 0x10 only while the block is idle; the block does not enforce this.
module heartbeat_loss_detector_top
#(
    parameter int CHANNELS   = 4,
    parameter int TIME_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hbld_pkg::in_beat_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hbld_pkg::out_beat_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbld_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    hbld_pkg::timeout_arr_t               timeouts;
    logic [hbld_pkg::MISS_W-1:0]          miss_limit;

    logic                                 s1_valid_reg;
    hbld_pkg::in_beat_t                   s1_data_reg;
    logic                                 s1_adv;
    logic                                 in_take;

    logic [TIME_WIDTH-1:0]                now_reg;
    logic [CHANNELS-1:0]                  lost_next;
    logic [hbld_pkg::FLAGS_W-1:0]         flags;

    logic                                 out_valid_reg;
    hbld_pkg::out_beat_t                  out_data_reg;

    hbld_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeouts   (timeouts),
        .miss_limit (miss_limit)
    );

    // Handshake: input register moves on when the output register is free
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
    end

    // Advance the time counter on a tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
        end
        else if (s1_adv && (s1_data_reg.cmd == hbld_pkg::CMD_TICK))
        begin
            now_reg <= now_reg + 1'b1;
        end
    end

    // Channel units
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        hbld_pkg::chan_ctl_t           ctl;
        logic [hbld_pkg::TIMEOUT_W-1:0] chan_timeout;

        assign ctl.heartbeat = s1_adv && (s1_data_reg.cmd == hbld_pkg::CMD_HEARTBEAT)
                               && (32'(s1_data_reg.channel) == 32'(i));
        assign ctl.scan      = s1_adv && (s1_data_reg.cmd == hbld_pkg::CMD_SCAN);

        if (i < hbld_pkg::TIMEOUT_REGS)
        begin : g_own
            assign chan_timeout = timeouts[i];
        end
        else
        begin : g_shared
            assign chan_timeout = timeouts[hbld_pkg::TIMEOUT_REGS-1];
        end

        hbld_chan #(.TIME_WIDTH(TIME_WIDTH)) u_chan
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .now        (now_reg),
            .timeout    (chan_timeout),
            .miss_limit (miss_limit),
            .lost_next  (lost_next[i])
        );
    end

    // Report the first four channels; missing ones read as not lost
    for (genvar j = 0; j < hbld_pkg::FLAGS_W; j++)
    begin : g_flag
        if (j < CHANNELS)
        begin : g_used
            assign flags[j] = lost_next[j];
        end
        else
        begin : g_unused
            assign flags[j] = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg.lost_flags    <= flags;
            out_data_reg.selected_lost <= flags[s1_data_reg.channel];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("output register not loaded after advance");

    a_selected_in_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.selected_lost) |-> (out_data_reg.lost_flags != '0))
        else $error("selected flag set with no lost flag");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_data_reg.cmd == hbld_pkg::CMD_TICK))
            |=> (now_reg == $past(now_reg) + 1'b1))
        else $error("time counter missed a tick");

    a_no_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && (s1_data_reg.cmd == hbld_pkg::CMD_TICK)) |=> $stable(now_reg))
        else $error("time counter moved without a tick");

endmodule
